@@ rtl/vpc_pkg.sv @@
// vpc_pkg: shared types and constants for the VoIP packet classifier.
// Used by vpc_front, vpc_queue, vpc_back and voip_packet_classifier.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vpc_pkg;

   // configuration register indexes
   localparam logic [3:0] CSR_L2_HEADER_LENGTH = 4'd0;
   localparam logic [3:0] CSR_ACTION_MODE      = 4'd1;

   localparam logic [6:0] L2_HEADER_LENGTH_RESET = 7'd14;

   // action modes
   localparam logic [2:0] MODE_PASS_RTP   = 3'd0;
   localparam logic [2:0] MODE_PASS_RTCP  = 3'd1;
   localparam logic [2:0] MODE_PASS_SIP   = 3'd2;
   localparam logic [2:0] MODE_PASS_VOIP  = 3'd3;
   localparam logic [2:0] MODE_STEER_RTP  = 3'd4;
   localparam logic [2:0] MODE_STEER_VOIP = 3'd5;

   localparam logic [15:0] IPV4_ETHER_TYPE = 16'h0800;
   localparam logic [7:0]  UDP_PROTOCOL    = 8'd17;
   localparam logic [15:0] SIP_PORT_A      = 16'd5060;
   localparam logic [15:0] SIP_PORT_B      = 16'd5061;
   localparam logic [15:0] LOW_PORT_LIMIT  = 16'd1024;
   localparam logic [7:0]  RTCP_SR_TYPE    = 8'd200;
   localparam logic [1:0]  RTP_VERSION     = 2'd2;
   localparam logic [7:0]  MIN_HEADER_BYTES = 8'd20;

   // offsets: ethertype from frame start, the rest from L3 / L4 start
   localparam logic [7:0] ETHER_TYPE_HI_POS = 8'd12;
   localparam logic [7:0] ETHER_TYPE_LO_POS = 8'd13;
   localparam logic [7:0] PROTOCOL_OFS      = 8'd9;
   localparam logic [7:0] SRC_ADDR_OFS      = 8'd12;
   localparam logic [7:0] DST_ADDR_OFS      = 8'd16;
   localparam logic [7:0] DST_ADDR_END      = 8'd20;
   localparam logic [7:0] RTP_FIRST_OFS     = 8'd8;
   localparam logic [7:0] RTP_SECOND_OFS    = 8'd9;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      CLASS_UNKNOWN = 2'd0,
      CLASS_RTP     = 2'd1,
      CLASS_RTCP    = 2'd2,
      CLASS_SIP     = 2'd3
   } class_type;

   typedef enum logic [1:0] {
      ACT_DROP      = 2'd0,
      ACT_PASS      = 2'd1,
      ACT_STEER     = 2'd2,
      ACT_BROADCAST = 2'd3
   } action_type;

   // header fields of one finished frame
   typedef struct packed {
      logic        too_short;
      logic [15:0] ether_type;
      logic [7:0]  ip_protocol;
      logic [31:0] source_address;
      logic [31:0] dest_address;
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic [7:0]  first_rtp_byte;
      logic [7:0]  second_rtp_byte;
   } frame_rec_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   function automatic logic codec_ok(input logic [7:0] c);
      return (c < 8'd19) || (c > 8'd95) || (c == 8'd25) || (c == 8'd26) ||
             (c == 8'd28) || (c == 8'd31) || (c == 8'd32) || (c == 8'd33) ||
             (c == 8'd34);
   endfunction

   function automatic logic [31:0] fold32(input logic [31:0] x);
      return x ^ {8'd0, x[31:8]} ^ {16'd0, x[31:16]} ^ {24'd0, x[31:24]};
   endfunction

   function automatic logic [31:0] swap_half(input logic [15:0] x);
      return {17'd0, x[7:0], x[15:9]};
   endfunction

endpackage

`default_nettype wire

@@ rtl/voip_packet_classifier.sv @@
// voip_packet_classifier: top level, configuration registers and assertions.
// Instantiates vpc_front, vpc_queue and vpc_back; depends on vpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Byte-serial VoIP frame classifier. Frame bytes are pushed one per clock in
// wire order; req_last_byte marks the final byte. Each frame yields exactly one
// result (action, class, steering hash); its record passes through the queue
// into the result register once that register is free. A byte is taken every
// cycle as long as the two-entry frame-record queue between the capture front
// end and the classifier has room; the classifier drains one record per cycle
// into the result register while it is free or being popped, so req_full only
// rises when results are popped more slowly than frames end. Configuration
// writes (index 0: L2 header length, index 1: action mode) are always accepted
// and should be issued only between frames with no result pending.

module voip_packet_classifier #(
   parameter int COUNT_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [7:0]  req_frame_byte,
   input  wire logic        req_last_byte,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [1:0]       rsp_action,
   output logic [1:0]       rsp_packet_class,
   output logic [31:0]      rsp_steer_hash,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [3:0]  csr_index,
   input  wire logic [7:0]  csr_wdata
);

   logic [6:0] l2_len_ff, l2_len_in;
   logic [2:0] mode_ff, mode_in;

   vpc_pkg::frame_rec_type    front_rec, head_rec;
   vpc_pkg::queue_status_type q_status;
   logic                      rec_push, rec_pop, byte_accept, rsp_valid;

   always_comb begin
      csr_ready = 1'b1;
      l2_len_in = l2_len_ff;
      mode_in   = mode_ff;
      if (csr_valid && csr_index == vpc_pkg::CSR_L2_HEADER_LENGTH) l2_len_in = csr_wdata[6:0];
      if (csr_valid && csr_index == vpc_pkg::CSR_ACTION_MODE)      mode_in   = csr_wdata[2:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         l2_len_ff <= vpc_pkg::L2_HEADER_LENGTH_RESET;
         mode_ff   <= vpc_pkg::MODE_STEER_VOIP;
      end else begin
         l2_len_ff <= l2_len_in;
         mode_ff   <= mode_in;
      end
   end

   assign req_full    = q_status.full;
   assign byte_accept = req_push && !q_status.full;
   assign rsp_empty   = !rsp_valid;

   vpc_front #(.COUNT_BITS(COUNT_BITS)) u_front (
      .clock            (clock),
      .reset            (reset),
      .byte_valid       (byte_accept),
      .frame_byte       (req_frame_byte),
      .last_byte        (req_last_byte),
      .l2_header_length (l2_len_ff),
      .rec_out          (front_rec),
      .rec_push         (rec_push)
   );

   vpc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (rec_push),
      .push_rec (front_rec),
      .pop      (rec_pop),
      .head_rec (head_rec),
      .status   (q_status)
   );

   vpc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .rec_valid    (!q_status.empty),
      .rec          (head_rec),
      .rec_pop      (rec_pop),
      .action_mode  (mode_ff),
      .rsp_valid    (rsp_valid),
      .rsp_take     (rsp_pop),
      .action       (rsp_action),
      .packet_class (rsp_packet_class),
      .steer_hash   (rsp_steer_hash)
   );

   // a finished frame must land in the queue
   assert property (@(posedge clock) disable iff (reset)
      byte_accept && req_last_byte |=> !q_status.empty)
      else $error("frame record lost on last byte");

   // hash only accompanies steering
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_action != vpc_pkg::ACT_STEER |-> rsp_steer_hash == 32'd0)
      else $error("nonzero hash without steer action");

   // broadcast is only for SIP
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_action == vpc_pkg::ACT_BROADCAST |->
         rsp_packet_class == vpc_pkg::CLASS_SIP)
      else $error("broadcast on non-SIP frame");

   // a pending record always moves into a free result register
   assert property (@(posedge clock) disable iff (reset)
      !q_status.empty && rsp_empty |=> !rsp_empty)
      else $error("classifier stalled with free result register");

endmodule

`default_nettype wire

@@ rtl/vpc_front.sv @@
// vpc_front: byte-serial header capture of the VoIP packet classifier.
// Counts frame bytes, captures header fields, emits one frame record per frame.
// Depends on vpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vpc_front #(
   parameter int COUNT_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   byte_valid,
   input  wire logic [7:0]             frame_byte,
   input  wire logic                   last_byte,
   input  wire logic [6:0]             l2_header_length,
   output vpc_pkg::frame_rec_type      rec_out,
   output logic                        rec_push
);

   localparam int LW = COUNT_BITS + 1;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   logic [COUNT_BITS-1:0] byte_count_ff, byte_count_in;
   logic [15:0] ether_type_ff, ether_type_in;
   logic [3:0]  header_words_ff, header_words_in;
   logic [7:0]  ip_protocol_ff, ip_protocol_in;
   logic [31:0] source_address_ff, source_address_in;
   logic [31:0] dest_address_ff, dest_address_in;
   logic [15:0] source_port_ff, source_port_in;
   logic [15:0] dest_port_ff, dest_port_in;
   logic [7:0]  first_rtp_ff, first_rtp_in;
   logic [7:0]  second_rtp_ff, second_rtp_in;

   logic [COUNT_BITS-1:0] p, l3_pos, l4_pos;
   logic [7:0]            l3, l4;
   logic [LW-1:0]         frame_len;

   function automatic logic [COUNT_BITS-1:0] at(input logic [7:0] base, input logic [7:0] ofs);
      return COUNT_BITS'(base) + COUNT_BITS'(ofs);
   endfunction

   always_comb begin
      p  = byte_count_ff;
      l3 = {1'b0, l2_header_length};
      l3_pos = COUNT_BITS'(l3);

      ether_type_in     = ether_type_ff;
      header_words_in   = header_words_ff;
      ip_protocol_in    = ip_protocol_ff;
      source_address_in = source_address_ff;
      dest_address_in   = dest_address_ff;
      source_port_in    = source_port_ff;
      dest_port_in      = dest_port_ff;
      first_rtp_in      = first_rtp_ff;
      second_rtp_in     = second_rtp_ff;

      if (p == COUNT_BITS'(vpc_pkg::ETHER_TYPE_HI_POS)) ether_type_in[15:8] = frame_byte;
      if (p == COUNT_BITS'(vpc_pkg::ETHER_TYPE_LO_POS)) ether_type_in[7:0]  = frame_byte;
      if (p == l3_pos) header_words_in = frame_byte[3:0];
      if (p == at(l3, vpc_pkg::PROTOCOL_OFS)) ip_protocol_in = frame_byte;
      if (p >= at(l3, vpc_pkg::SRC_ADDR_OFS) && p < at(l3, vpc_pkg::DST_ADDR_OFS))
         source_address_in = {frame_byte, source_address_ff[31:8]};
      if (p >= at(l3, vpc_pkg::DST_ADDR_OFS) && p < at(l3, vpc_pkg::DST_ADDR_END))
         dest_address_in = {frame_byte, dest_address_ff[31:8]};

      // the IHL byte already moves the L4 offset for itself
      l4     = l3 + {2'b00, header_words_in, 2'b00};
      l4_pos = COUNT_BITS'(l4);
      if (p == l4_pos)                        source_port_in[15:8] = frame_byte;
      if (p == at(l4, 8'd1))                  source_port_in[7:0]  = frame_byte;
      if (p == at(l4, 8'd2))                  dest_port_in[15:8]   = frame_byte;
      if (p == at(l4, 8'd3))                  dest_port_in[7:0]    = frame_byte;
      if (p == at(l4, vpc_pkg::RTP_FIRST_OFS))  first_rtp_in       = frame_byte;
      if (p == at(l4, vpc_pkg::RTP_SECOND_OFS)) second_rtp_in      = frame_byte;

      frame_len = LW'(p) + LW'(1);
   end

   always_comb begin
      rec_out.too_short = (frame_len < LW'(l3) + LW'(vpc_pkg::MIN_HEADER_BYTES)) ||
                          (frame_len < LW'(l4) + LW'(vpc_pkg::MIN_HEADER_BYTES));
      rec_out.ether_type      = ether_type_in;
      rec_out.ip_protocol     = ip_protocol_in;
      rec_out.source_address  = source_address_in;
      rec_out.dest_address    = dest_address_in;
      rec_out.source_port     = source_port_in;
      rec_out.dest_port       = dest_port_in;
      rec_out.first_rtp_byte  = first_rtp_in;
      rec_out.second_rtp_byte = second_rtp_in;
      rec_push = byte_valid && last_byte;
      byte_count_in = (byte_count_ff == COUNT_MAX) ? byte_count_ff
                                                   : byte_count_ff + COUNT_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (reset || (byte_valid && last_byte)) begin
         byte_count_ff     <= '0;
         ether_type_ff     <= '0;
         header_words_ff   <= '0;
         ip_protocol_ff    <= '0;
         source_address_ff <= '0;
         dest_address_ff   <= '0;
         source_port_ff    <= '0;
         dest_port_ff      <= '0;
         first_rtp_ff      <= '0;
         second_rtp_ff     <= '0;
      end else if (byte_valid) begin
         byte_count_ff     <= byte_count_in;
         ether_type_ff     <= ether_type_in;
         header_words_ff   <= header_words_in;
         ip_protocol_ff    <= ip_protocol_in;
         source_address_ff <= source_address_in;
         dest_address_ff   <= dest_address_in;
         source_port_ff    <= source_port_in;
         dest_port_ff      <= dest_port_in;
         first_rtp_ff      <= first_rtp_in;
         second_rtp_ff     <= second_rtp_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/vpc_queue.sv @@
// vpc_queue: short queue of frame records between front and back.
// Depends on vpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vpc_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  vpc_pkg::frame_rec_type      push_rec,
   input  wire logic                   pop,
   output vpc_pkg::frame_rec_type      head_rec,
   output vpc_pkg::queue_status_type   status
);

   localparam int PTR_BITS = $clog2(vpc_pkg::QUEUE_DEPTH);
   localparam int CNT_BITS = PTR_BITS + 1;

   vpc_pkg::frame_rec_type entries [vpc_pkg::QUEUE_DEPTH];

   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   always_comb begin
      status.empty = (count_ff == '0);
      status.full  = (count_ff == CNT_BITS'(vpc_pkg::QUEUE_DEPTH));
      do_push   = push && !status.full;
      do_pop    = pop && !status.empty;
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_BITS'(do_push) - CNT_BITS'(do_pop);
      head_rec  = entries[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

`default_nettype wire

@@ rtl/vpc_back.sv @@
// vpc_back: classifies queued frame records, picks the action and the hash.
// Holds the result register. Depends on vpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vpc_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   rec_valid,
   input  vpc_pkg::frame_rec_type      rec,
   output logic                        rec_pop,
   input  wire logic [2:0]             action_mode,
   output logic                        rsp_valid,
   input  wire logic                   rsp_take,
   output logic [1:0]                  action,
   output logic [1:0]                  packet_class,
   output logic [31:0]                 steer_hash
);

   vpc_pkg::class_type  cls;
   vpc_pkg::action_type act;
   logic [31:0]         hash;
   logic                sip_port, low_port, sp_odd, dp_odd;

   logic                out_valid_ff, out_valid_in;
   logic [1:0]          action_ff, class_ff;
   logic [31:0]         hash_ff;

   always_comb begin
      sip_port = (rec.dest_port == vpc_pkg::SIP_PORT_A) ||
                 (rec.source_port == vpc_pkg::SIP_PORT_A) ||
                 (rec.dest_port == vpc_pkg::SIP_PORT_B) ||
                 (rec.source_port == vpc_pkg::SIP_PORT_B);
      low_port = (rec.dest_port < vpc_pkg::LOW_PORT_LIMIT) ||
                 (rec.source_port < vpc_pkg::LOW_PORT_LIMIT);
      sp_odd   = rec.source_port[0];
      dp_odd   = rec.dest_port[0];

      priority if (rec.ether_type != vpc_pkg::IPV4_ETHER_TYPE) cls = vpc_pkg::CLASS_UNKNOWN;
      else if (rec.too_short)                                  cls = vpc_pkg::CLASS_UNKNOWN;
      else if (sip_port)                                       cls = vpc_pkg::CLASS_SIP;
      else if (rec.ip_protocol != vpc_pkg::UDP_PROTOCOL)       cls = vpc_pkg::CLASS_UNKNOWN;
      else if (rec.first_rtp_byte[7:6] != vpc_pkg::RTP_VERSION) cls = vpc_pkg::CLASS_UNKNOWN;
      else if (low_port)                                       cls = vpc_pkg::CLASS_UNKNOWN;
      else if (sp_odd && dp_odd)
         cls = (rec.second_rtp_byte == vpc_pkg::RTCP_SR_TYPE) ? vpc_pkg::CLASS_RTCP
                                                               : vpc_pkg::CLASS_UNKNOWN;
      else if (!sp_odd && !dp_odd && !vpc_pkg::codec_ok(rec.second_rtp_byte))
         cls = vpc_pkg::CLASS_UNKNOWN;
      else
         cls = vpc_pkg::CLASS_RTP;
   end

   always_comb begin
      act  = vpc_pkg::ACT_DROP;
      hash = '0;
      unique case (action_mode)
         vpc_pkg::MODE_PASS_RTP:
            if (cls == vpc_pkg::CLASS_RTP) act = vpc_pkg::ACT_PASS;
         vpc_pkg::MODE_PASS_RTCP:
            if (cls == vpc_pkg::CLASS_RTCP) act = vpc_pkg::ACT_PASS;
         vpc_pkg::MODE_PASS_SIP:
            if (cls == vpc_pkg::CLASS_SIP) act = vpc_pkg::ACT_PASS;
         vpc_pkg::MODE_PASS_VOIP:
            if (cls != vpc_pkg::CLASS_UNKNOWN) act = vpc_pkg::ACT_PASS;
         vpc_pkg::MODE_STEER_RTP, vpc_pkg::MODE_STEER_VOIP: begin
            if (cls == vpc_pkg::CLASS_RTP || cls == vpc_pkg::CLASS_RTCP) begin
               act  = vpc_pkg::ACT_STEER;
               hash = vpc_pkg::fold32(rec.source_address) ^
                      vpc_pkg::fold32(rec.dest_address) ^
                      vpc_pkg::swap_half(rec.source_port) ^
                      vpc_pkg::swap_half(rec.dest_port);
            end else if (cls == vpc_pkg::CLASS_SIP &&
                         action_mode == vpc_pkg::MODE_STEER_VOIP) begin
               act = vpc_pkg::ACT_BROADCAST;
            end
         end
         default: act = vpc_pkg::ACT_DROP;
      endcase
   end

   // load a new result when the register is free or drains this cycle
   always_comb begin
      rec_pop      = rec_valid && (!out_valid_ff || rsp_take);
      out_valid_in = rec_pop || (out_valid_ff && !rsp_take);
      rsp_valid    = out_valid_ff;
      action       = action_ff;
      packet_class = class_ff;
      steer_hash   = hash_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rec_pop) begin
         action_ff <= act;
         class_ff  <= cls;
         hash_ff   <= hash;
      end
   end

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// tb_top: self-checking testbench for voip_packet_classifier.
// Streams directed and random Ethernet frames byte by byte, predicts each verdict
// in-line or takes a typed row's; checks results. Depends on vpc_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
   import vpc_pkg::*;

   localparam int          DRAIN_CYCLES = 6;
   localparam int          END_WAIT_LIMIT = 200000;
   localparam int          DIRECTED_ROWS = 27;
   localparam int          RANDOM_SUBS = 2;
   localparam logic [2:0]  MODE_RESERVED_A = 3'd6;
   localparam logic [2:0]  MODE_RESERVED_B = 3'd7;
   localparam logic [31:0] ADDR_A = 32'hC0A8_0101;
   localparam logic [31:0] ADDR_B = 32'h0A00_0002;

   typedef struct packed {
      action_type  act;
      class_type   cls;
      logic [31:0] hash;
   } frame_verdict_type;

   // header content of one frame; length is relative to the minimum L4 length
   typedef struct {
      logic [15:0] ether_type;
      logic [7:0]  ver_ihl;
      logic [7:0]  protocol;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [7:0]  rtp_flags;
      logic [7:0]  rtp_type;
      int          len_delta;
   } frame_spec_type;

   typedef struct {
      logic [6:0]     l2_len;
      logic [2:0]     mode;
      bit             typed;
      action_type     act;
      class_type      cls;
      frame_spec_type spec;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_frame_byte = 8'd0;
   logic        req_last_byte = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [1:0]  rsp_action;
   logic [1:0]  rsp_packet_class;
   logic [31:0] rsp_steer_hash;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_index = 4'd0;
   logic [7:0]  csr_wdata = 8'd0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count = 0;

   frame_verdict_type pending_verdicts[$];
   logic [7:0]        frame_buf[$];
   directed_row_type  directed_rows [DIRECTED_ROWS];

   // predictor copy of the configuration and capture registers
   logic [6:0]  cfg_l2_len = L2_HEADER_LENGTH_RESET;
   logic [2:0]  cfg_mode = MODE_STEER_VOIP;
   logic [15:0] frm_count = '0;
   logic [15:0] frm_ether_type = '0;
   logic [3:0]  frm_ihl = '0;
   logic [7:0]  frm_protocol = '0;
   logic [31:0] frm_src_addr = '0;
   logic [31:0] frm_dst_addr = '0;
   logic [15:0] frm_src_port = '0;
   logic [15:0] frm_dst_port = '0;
   logic [7:0]  frm_rtp_flags = '0;
   logic [7:0]  frm_rtp_type = '0;

   voip_packet_classifier dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_frame_byte   (req_frame_byte),
      .req_last_byte    (req_last_byte),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_action       (rsp_action),
      .rsp_packet_class (rsp_packet_class),
      .rsp_steer_hash   (rsp_steer_hash),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [31:0] xor_fold(input logic [31:0] x);
      return x ^ (x >> 8) ^ (x >> 16) ^ (x >> 24);
   endfunction

   function automatic logic codec_allowed(input logic [7:0] c);
      return (c < 8'd19) || (c > 8'd95) || (c == 8'd25) || (c == 8'd26) ||
             (c == 8'd28) || (c == 8'd31) || (c == 8'd32) || (c == 8'd33) ||
             (c == 8'd34);
   endfunction

   function automatic class_type classify_frame(input int length);
      int l3;
      int l4;
      l3 = cfg_l2_len;
      l4 = l3 + 4 * frm_ihl;
      if (frm_ether_type != IPV4_ETHER_TYPE) return CLASS_UNKNOWN;
      if (length < l3 + MIN_HEADER_BYTES || length < l4 + MIN_HEADER_BYTES)
         return CLASS_UNKNOWN;
      // SIP is decided before the protocol test
      if (frm_src_port == SIP_PORT_A || frm_dst_port == SIP_PORT_A ||
          frm_src_port == SIP_PORT_B || frm_dst_port == SIP_PORT_B) return CLASS_SIP;
      if (frm_protocol != UDP_PROTOCOL) return CLASS_UNKNOWN;
      if (frm_rtp_flags[7:6] != RTP_VERSION) return CLASS_UNKNOWN;
      if (frm_src_port < LOW_PORT_LIMIT || frm_dst_port < LOW_PORT_LIMIT)
         return CLASS_UNKNOWN;
      if (frm_src_port[0] && frm_dst_port[0]) begin
         if (frm_rtp_type == RTCP_SR_TYPE) return CLASS_RTCP;
         return CLASS_UNKNOWN;
      end
      if (!frm_src_port[0] && !frm_dst_port[0] && !codec_allowed(frm_rtp_type))
         return CLASS_UNKNOWN;
      return CLASS_RTP;
   endfunction

   function automatic logic [31:0] steer_hash_of();
      logic [15:0] sp_swapped;
      logic [15:0] dp_swapped;
      sp_swapped = {frm_src_port[7:0], frm_src_port[15:8]};
      dp_swapped = {frm_dst_port[7:0], frm_dst_port[15:8]};
      return xor_fold(frm_src_addr) ^ xor_fold(frm_dst_addr) ^
             {17'd0, sp_swapped[15:1]} ^ {17'd0, dp_swapped[15:1]};
   endfunction

   // Advances the capture state by one byte; on the last byte yields the verdict.
   task automatic track_frame_byte(input logic [7:0] b, input logic last,
                                   output logic have, output frame_verdict_type v);
      int p;
      int l3;
      int l4;
      p = frm_count;
      l3 = cfg_l2_len;
      have = 1'b0;
      v = '{ACT_DROP, CLASS_UNKNOWN, 32'd0};
      if (p == ETHER_TYPE_HI_POS) frm_ether_type[15:8] = b;
      if (p == ETHER_TYPE_LO_POS) frm_ether_type[7:0] = b;
      // IHL applies to the same byte it arrives on
      if (p == l3) frm_ihl = b[3:0];
      if (p == l3 + PROTOCOL_OFS) frm_protocol = b;
      if (p >= l3 + SRC_ADDR_OFS && p < l3 + DST_ADDR_OFS)
         frm_src_addr = {b, frm_src_addr[31:8]};
      if (p >= l3 + DST_ADDR_OFS && p < l3 + DST_ADDR_END)
         frm_dst_addr = {b, frm_dst_addr[31:8]};
      l4 = l3 + 4 * frm_ihl;
      if (p == l4) frm_src_port[15:8] = b;
      if (p == l4 + 1) frm_src_port[7:0] = b;
      if (p == l4 + 2) frm_dst_port[15:8] = b;
      if (p == l4 + 3) frm_dst_port[7:0] = b;
      if (p == l4 + RTP_FIRST_OFS) frm_rtp_flags = b;
      if (p == l4 + RTP_SECOND_OFS) frm_rtp_type = b;
      if (!last) begin
         if (frm_count != 16'hFFFF) frm_count = frm_count + 16'd1;
      end else begin
         have = 1'b1;
         v.cls = classify_frame(p + 1);
         case (cfg_mode)
            MODE_PASS_RTP:  if (v.cls == CLASS_RTP) v.act = ACT_PASS;
            MODE_PASS_RTCP: if (v.cls == CLASS_RTCP) v.act = ACT_PASS;
            MODE_PASS_SIP:  if (v.cls == CLASS_SIP) v.act = ACT_PASS;
            MODE_PASS_VOIP: if (v.cls != CLASS_UNKNOWN) v.act = ACT_PASS;
            MODE_STEER_RTP, MODE_STEER_VOIP: begin
               if (v.cls == CLASS_RTP || v.cls == CLASS_RTCP) begin
                  v.act = ACT_STEER;
                  v.hash = steer_hash_of();
               end else if (v.cls == CLASS_SIP && cfg_mode == MODE_STEER_VOIP) begin
                  v.act = ACT_BROADCAST;
               end
            end
            default: v.act = ACT_DROP;
         endcase
         frm_count = '0;
         frm_ether_type = '0;
         frm_ihl = '0;
         frm_protocol = '0;
         frm_src_addr = '0;
         frm_dst_addr = '0;
         frm_src_port = '0;
         frm_dst_port = '0;
         frm_rtp_flags = '0;
         frm_rtp_type = '0;
      end
   endtask

   // Lays the header fields over random filler at the current L2 length.
   task automatic build_frame(input frame_spec_type s);
      int l3;
      int l4;
      int len;
      int i;
      l3 = cfg_l2_len;
      l4 = l3 + 4 * s.ver_ihl[3:0];
      len = l4 + MIN_HEADER_BYTES + s.len_delta;
      if (len < 1) len = 1;
      frame_buf.delete();
      for (i = 0; i < len; i++) frame_buf.push_back(8'($urandom_range(0, 255)));
      for (i = 0; i < len; i++) begin
         if (i == ETHER_TYPE_HI_POS) frame_buf[i] = s.ether_type[15:8];
         if (i == ETHER_TYPE_LO_POS) frame_buf[i] = s.ether_type[7:0];
         if (i == l3) frame_buf[i] = s.ver_ihl;
         if (i == l3 + PROTOCOL_OFS) frame_buf[i] = s.protocol;
         if (i >= l3 + SRC_ADDR_OFS && i < l3 + DST_ADDR_OFS)
            frame_buf[i] = s.src_addr[8 * (l3 + DST_ADDR_OFS - 1 - i) +: 8];
         if (i >= l3 + DST_ADDR_OFS && i < l3 + DST_ADDR_END)
            frame_buf[i] = s.dst_addr[8 * (l3 + DST_ADDR_END - 1 - i) +: 8];
         // later fields win where a short IHL makes them overlap
         if (i == l4) frame_buf[i] = s.src_port[15:8];
         if (i == l4 + 1) frame_buf[i] = s.src_port[7:0];
         if (i == l4 + 2) frame_buf[i] = s.dst_port[15:8];
         if (i == l4 + 3) frame_buf[i] = s.dst_port[7:0];
         if (i == l4 + RTP_FIRST_OFS) frame_buf[i] = s.rtp_flags;
         if (i == l4 + RTP_SECOND_OFS) frame_buf[i] = s.rtp_type;
      end
   endtask

   function automatic logic [15:0] random_port(input logic odd);
      logic [15:0] port;
      port = 16'($urandom_range(1024, 65535));
      port[0] = odd;
      return port;
   endfunction

   task automatic make_random_frame(output frame_spec_type s);
      int pick;
      s.src_addr = $urandom();
      s.dst_addr = $urandom();
      if ($urandom_range(0, 9) == 0) begin
         // noise: nothing steered toward a valid header
         s.ether_type = 16'($urandom());
         s.ver_ihl = 8'($urandom());
         s.protocol = 8'($urandom());
         s.src_port = 16'($urandom());
         s.dst_port = 16'($urandom());
         s.rtp_flags = 8'($urandom());
         s.rtp_type = 8'($urandom());
         s.len_delta = int'($urandom_range(0, 60)) - 40;
      end else begin
         s.ether_type = ($urandom_range(0, 19) == 0) ? 16'($urandom()) : IPV4_ETHER_TYPE;
         s.ver_ihl = ($urandom_range(0, 4) == 0) ? 8'($urandom()) : 8'h45;
         s.protocol = ($urandom_range(0, 6) == 0) ? 8'($urandom()) : UDP_PROTOCOL;
         pick = $urandom_range(0, 9);
         case (pick)
            0: begin
               s.src_port = random_port(1'($urandom_range(0, 1)));
               s.dst_port = $urandom_range(0, 1) ? SIP_PORT_A : SIP_PORT_B;
               if ($urandom_range(0, 1)) {s.src_port, s.dst_port} = {s.dst_port, s.src_port};
            end
            1: begin
               s.src_port = 16'($urandom_range(0, 1023));
               s.dst_port = random_port(1'($urandom_range(0, 1)));
               if ($urandom_range(0, 1)) {s.src_port, s.dst_port} = {s.dst_port, s.src_port};
            end
            2, 3: begin
               s.src_port = random_port(1'b0);
               s.dst_port = random_port(1'b0);
            end
            4, 5: begin
               s.src_port = random_port(1'b1);
               s.dst_port = random_port(1'b1);
            end
            6, 7: begin
               s.src_port = random_port(1'b0);
               s.dst_port = random_port(1'b1);
               if ($urandom_range(0, 1)) {s.src_port, s.dst_port} = {s.dst_port, s.src_port};
            end
            default: begin
               s.src_port = 16'($urandom());
               s.dst_port = 16'($urandom());
            end
         endcase
         s.rtp_flags = ($urandom_range(0, 6) == 0) ? 8'($urandom())
                                                   : {2'b10, 6'($urandom())};
         pick = $urandom_range(0, 9);
         if (pick < 3) begin
            s.rtp_type = RTCP_SR_TYPE;
         end else if (pick < 6) begin
            case ($urandom_range(0, 6))
               0: s.rtp_type = 8'd25;
               1: s.rtp_type = 8'd26;
               2: s.rtp_type = 8'd28;
               3: s.rtp_type = 8'd31;
               4: s.rtp_type = 8'd32;
               5: s.rtp_type = 8'd33;
               default: s.rtp_type = 8'd34;
            endcase
         end else begin
            s.rtp_type = 8'($urandom());
         end
         pick = $urandom_range(0, 19);
         if (pick < 14) s.len_delta = $urandom_range(0, 6);
         else if (pick < 17) s.len_delta = -int'($urandom_range(1, 30));
         else s.len_delta = $urandom_range(7, 40);
      end
   endtask

   task automatic push_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_frame_byte <= b;
      req_last_byte <= last;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   task automatic send_frame(input bit typed, input frame_verdict_type typed_verdict);
      int i;
      logic have;
      frame_verdict_type v;
      for (i = 0; i < frame_buf.size(); i++) begin
         push_byte(frame_buf[i], i == frame_buf.size() - 1);
         track_frame_byte(frame_buf[i], i == frame_buf.size() - 1, have, v);
         if (have) pending_verdicts.push_back(typed ? typed_verdict : v);
      end
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [3:0] idx, input logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_L2_HEADER_LENGTH) cfg_l2_len = val[6:0];
      else if (idx == CSR_ACTION_MODE) cfg_mode = val[2:0];
      @(posedge clock);
   endtask

   task automatic apply_config(input logic [6:0] l2_len, input logic [2:0] mode);
      if (l2_len != cfg_l2_len || mode != cfg_mode) wait_drained();
      if (l2_len != cfg_l2_len) write_csr(CSR_L2_HEADER_LENGTH, {1'b0, l2_len});
      if (mode != cfg_mode) write_csr(CSR_ACTION_MODE, {5'd0, mode});
   endtask

   // result side: pop at random and compare each transaction with the oldest verdict
   initial begin
      frame_verdict_type want;
      forever begin
         @(posedge clock);
         if (rsp_pop && !rsp_empty) begin
            if (pending_verdicts.size() == 0) begin
               $display("%0t: unexpected result: action %0d class %0d hash %h",
                        $time, rsp_action, rsp_packet_class, rsp_steer_hash);
               error_count++;
            end else begin
               want = pending_verdicts.pop_front();
               if (rsp_action !== want.act) begin
                  $display("%0t: action mismatch: expected %0d, got %0d",
                           $time, want.act, rsp_action);
                  error_count++;
               end
               if (rsp_packet_class !== want.cls) begin
                  $display("%0t: packet_class mismatch: expected %0d, got %0d",
                           $time, want.cls, rsp_packet_class);
                  error_count++;
               end
               if (rsp_steer_hash !== want.hash) begin
                  $display("%0t: steer_hash mismatch: expected %h, got %h",
                           $time, want.hash, rsp_steer_hash);
                  error_count++;
               end
            end
         end
         rsp_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   initial begin
      #8000000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      int row;
      int phase;
      int sub;
      int waited;
      logic [6:0] next_len;
      frame_spec_type spec;

      directed_rows = '{
         // after reset: non-IPv4 ethertype
         '{7'd14, MODE_STEER_VOIP, 1'b1, ACT_DROP, CLASS_UNKNOWN,
           '{16'h86DD, 8'h45, UDP_PROTOCOL, ADDR_A, ADDR_B, 16'd4000, 16'd4002,
             8'h80, 8'd0, 0}},
         '{7'd14, MODE_STEER_VOIP, 1'b1, ACT_BROADCAST, CLASS_SIP,
           '{IPV4_ETHER_TYPE, 8'h45, UDP_PROTOCOL, ADDR_A, ADDR_B, 16'd40000, SIP_PORT_A,
             8'h00, 8'd0, 0}},
         // SIP wins over a non-UDP protocol
         '{7'd14, MODE_STEER_VOIP, 1'b1, ACT_BROADCAST, CLASS_SIP,
           '{IPV4_ETHER_TYPE, 8'h45, 8'd6, ADDR_A, ADDR_B, SIP_PORT_B, 16'd80,
             8'h00, 8'd0, 3}},
         // one byte short of the minimum length
         '{7'd14, MODE_STEER_VOIP, 1'b1, ACT_DROP, CLASS_UNKNOWN,
           '{IPV4_ETHER_TYPE, 8'h45, UDP_PROTOCOL, ADDR_A, ADDR_B, SIP_PORT_A, 16'd5062,
             8'h80, 8'd0, -1}},
         // single-byte frame
         '{7'd14, MODE_STEER_VOIP, 1'b1, ACT_DROP, CLASS_UNKNOWN,
           '{IPV4_ETHER_TYPE, 8'h45, UDP_PROTOCOL, ADDR_A, ADDR_B, 16'd4000, 16'd4002,
             8'h80, 8'd0, -1000}},
         '{7'd14, MODE_STEER_VOIP, 1'b0, ACT_DROP, CLASS_UNKNOWN,
           '{IPV4_ETHER_TYPE, 8'h45, UDP_PROTOCOL, ADDR_A, ADDR_B, 16'd4000, 16'd4002,
             8'h80, 8'd0, 0}},
         '{7'd14, MODE_STEER_VOIP, 1'b0, ACT_DROP, CLASS_UNKNOWN,
           '{IPV4_ETHER_TYPE, 8'h45, UDP_PROTOCOL, ADDR_A, ADDR_B, 16'd4001, 16'd4003,
             8'h81, RTCP_SR_TYPE, 5}},
         '{7'd14, MODE_STEER_VOIP, 1'b1, ACT_DROP, CLASS_UNKNOWN,
           '{IPV4_ETHER_TYPE, 8'h45, UDP_PROTOCOL, ADDR_A, ADDR_B, 16'd4001, 16'd4003,
             8'h80, 8'd201, 0}},
         '{7'd14, MODE_STEER_VOIP, 1'b1, ACT_DROP, CLASS_UNKNOWN,
           '{IPV4_ETHER_TYPE, 8'h45, 8'd6, ADDR_A, ADDR_B, 16'd4000, 16'd4002,
             8'h80, 8'd0, 0}},
         // wrong RTP version
         '{7'd14, MODE_STEER_VOIP, 1'b1, ACT_DROP, CLASS_UNKNOWN,
           '{IPV4_ETHER_TYPE, 8'h45, UDP_PROTOCOL, ADDR_A, ADDR_B, 16'd4000, 16'd4002,
             8'hC0, 8'd0, 0}},
         '{7'd14, MODE_STEER_VOIP, 1'b1, ACT_DROP, CLASS_UNKNOWN,
           '{IPV4_ETHER_TYPE, 8'h45, UDP_PROTOCOL, ADDR_A, ADDR_B, 16'd1023, 16'd4000,
             8'h80, 8'd0, 0}},
         '{7'd14, MODE_STEER_VOIP, 1'b1, ACT_DROP, CLASS_UNKNOWN,
           '{IPV4_ETHER_TYPE, 8'h45, UDP_PROTOCOL, ADDR_A, ADDR_B, 16'd4000, 16'd4002,
             8'h80, 8'd50, 0}},
         '{7'd14, MODE_STEER_VOIP, 1'b0, ACT_DROP, CLASS_UNKNOWN,
           '{IPV4_ETHER_TYPE, 8'h45, UDP_PROTOCOL, ADDR_A, ADDR_B, 16'd4000, 16'd4002,
             8'h80, 8'd96, 0}},
         // marker bit set on an otherwise static codec
         '{7'd14, MODE_STEER_VOIP, 1'b0, ACT_DROP, CLASS_UNKNOWN,
           '{IPV4_ETHER_TYPE, 8'h45, UDP_PROTOCOL, ADDR_A, ADDR_B, 16'd4000, 16'd4002,
             8'h80, 8'h80, 0}},
         '{7'd14, MODE_STEER_VOIP, 1'b0, ACT_DROP, CLASS_UNKNOWN,
           '{IPV4_ETHER_TYPE, 8'h45, UDP_PROTOCOL, ADDR_A, ADDR_B, 16'd4000, 16'd4002,
             8'h80, 8'd34, 0}},
         '{7'd14, MODE_STEER_VOIP, 1'b1, ACT_DROP, CLASS_UNKNOWN,
           '{IPV4_ETHER_TYPE, 8'h45, UDP_PROTOCOL, ADDR_A, ADDR_B, 16'd4000, 16'd4002,
             8'h80, 8'd19, 0}},
         '{7'd14, MODE_STEER_VOIP, 1'b1, ACT_DROP, CLASS_UNKNOWN,
           '{IPV4_ETHER_TYPE, 8'h45, UDP_PROTOCOL, ADDR_A, ADDR_B, 16'd4000, 16'd4002,
             8'h80, 8'd95, 0}},
         '{7'd14, MODE_STEER_VOIP, 1'b0, ACT_DROP, CLASS_UNKNOWN,
           '{IPV4_ETHER_TYPE, 8'h45, UDP_PROTOCOL, ADDR_A, ADDR_B, 16'd4000, 16'd4001,
             8'h80, 8'd50, 0}},
         // largest IHL and all-ones fields
         '{7'd14, MODE_STEER_VOIP, 1'b0, ACT_DROP, CLASS_UNKNOWN,
           '{IPV4_ETHER_TYPE, 8'h4F, UDP_PROTOCOL, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             16'hFFFF, 16'hFFFF, 8'hBF, RTCP_SR_TYPE, 0}},
         // IHL of zero: ports overlap the IP header
         '{7'd14, MODE_STEER_VOIP, 1'b0, ACT_DROP, CLASS_UNKNOWN,
           '{IPV4_ETHER_TYPE, 8'h40, UDP_PROTOCOL, ADDR_A, ADDR_B, 16'd4000, 16'd4002,
             8'h80, 8'd0, 0}},
         '{7'd64, MODE_PASS_RTP, 1'b0, ACT_DROP, CLASS_UNKNOWN,
           '{IPV4_ETHER_TYPE, 8'h45, UDP_PROTOCOL, ADDR_A, ADDR_B, 16'd4000, 16'd4002,
             8'h80, 8'd0, 0}},
         '{7'd64, MODE_PASS_RTCP, 1'b0, ACT_DROP, CLASS_UNKNOWN,
           '{IPV4_ETHER_TYPE, 8'h45, UDP_PROTOCOL, ADDR_A, ADDR_B, 16'd4001, 16'd4003,
             8'h80, RTCP_SR_TYPE, 0}},
         '{7'd64, MODE_PASS_SIP, 1'b1, ACT_PASS, CLASS_SIP,
           '{IPV4_ETHER_TYPE, 8'h45, UDP_PROTOCOL, ADDR_A, ADDR_B, SIP_PORT_A, 16'd4000,
             8'h80, 8'd0, 0}},
         '{7'd14, MODE_PASS_VOIP, 1'b0, ACT_DROP, CLASS_UNKNOWN,
           '{IPV4_ETHER_TYPE, 8'h45, UDP_PROTOCOL, ADDR_A, ADDR_B, 16'd4000, 16'd4001,
             8'h80, 8'd0, 0}},
         '{7'd14, MODE_STEER_RTP, 1'b1, ACT_DROP, CLASS_SIP,
           '{IPV4_ETHER_TYPE, 8'h45, UDP_PROTOCOL, ADDR_A, ADDR_B, 16'd4000, SIP_PORT_B,
             8'h80, 8'd0, 0}},
         // unused modes drop everything
         '{7'd14, MODE_RESERVED_A, 1'b1, ACT_DROP, CLASS_RTP,
           '{IPV4_ETHER_TYPE, 8'h45, UDP_PROTOCOL, ADDR_A, ADDR_B, 16'd4000, 16'd4002,
             8'h80, 8'd0, 0}},
         '{7'd14, MODE_RESERVED_B, 1'b1, ACT_DROP, CLASS_RTCP,
           '{IPV4_ETHER_TYPE, 8'h45, UDP_PROTOCOL, ADDR_A, ADDR_B, 16'd4001, 16'd4003,
             8'h80, RTCP_SR_TYPE, 0}}
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 15;
      recv_idle_pct = 59;
      for (row = 0; row < DIRECTED_ROWS; row++) begin
         apply_config(directed_rows[row].l2_len, directed_rows[row].mode);
         build_frame(directed_rows[row].spec);
         send_frame(directed_rows[row].typed,
                    '{directed_rows[row].act, directed_rows[row].cls, 32'd0});
      end

      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 59 : 0;
         recv_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 15 : 0;
         for (sub = 0; sub < RANDOM_SUBS; sub++) begin
            next_len = (sub == 0) ? 7'd14 : 7'($urandom_range(14, 64));
            // the result side empties out completely before each reconfiguration
            wait_drained();
            write_csr(CSR_L2_HEADER_LENGTH, {1'b0, next_len});
            write_csr(CSR_ACTION_MODE, {5'd0, 3'((2 * phase + sub) % 6)});
            make_random_frame(spec);
            build_frame(spec);
            send_frame(1'b0, '{ACT_DROP, CLASS_UNKNOWN, 32'd0});
         end
      end

      req_push <= 1'b0;
      waited = 0;
      while (pending_verdicts.size() != 0 && waited < END_WAIT_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_verdicts.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, pending_verdicts.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
